### sv/gbnw_pkg.sv
// ----------------------------------------------------------------------------
// gbnw_pkg
// Shared constants, codes and types of the go-back-N window sender.
// ----------------------------------------------------------------------------
package gbnw_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SEQ_BITS   = 16;
	localparam int BURST_MAX  = 64;

	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int CNT_W   = SEQ_BITS + 1;
	localparam int WSUM_W  = CNT_W + 1;
	localparam int BURST_W = $clog2(BURST_MAX);
	localparam int TOTAL_W = 16;
	localparam int MODE_W  = 2;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 1'd1;

	localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(3);
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1);

	typedef struct packed {
		logic load_event;
		logic emit;
	} gbnw_cmd_t;

	typedef struct packed {
		logic can_send;
		logic last_send;
		logic out_free;
	} gbnw_status_t;

	function automatic logic [WIN_W-1:0] clamp_win(input logic [WSUM_W-1:0] w);
		logic [WIN_W-1:0] r;
		if (w == '0) begin
			r = WIN_W'(1);
		end else if (w > WSUM_W'(MAX_WINDOW)) begin
			r = WIN_W'(MAX_WINDOW);
		end else begin
			r = w[WIN_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/gbnw_evt_if.sv
// ----------------------------------------------------------------------------
// gbnw_evt_if
// Event channel: start kick, ack or timeout, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbnw_evt_if
	import gbnw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SEQ_BITS-1:0] ack_seq;

	modport source (output valid, mode, ack_seq, input ready);
	modport sink   (input valid, mode, ack_seq, output ready);
endinterface

### sv/gbnw_res_if.sv
// ----------------------------------------------------------------------------
// gbnw_res_if
// Result channel: send orders and status items, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbnw_res_if
	import gbnw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                send_valid;
	logic [SEQ_BITS-1:0] packet_seq;
	logic                last;
	logic [WIN_W-1:0]    window;
	logic                all_acked;

	modport source (output valid, send_valid, packet_seq, last, window, all_acked,
		input ready);
	modport sink   (input valid, send_valid, packet_seq, last, window, all_acked,
		output ready);
endinterface

### sv/gbnw_ctrl.sv
// ----------------------------------------------------------------------------
// gbnw_ctrl
// Controller: takes one event, then steps the datapath through its burst.
// ----------------------------------------------------------------------------
module gbnw_ctrl
	import gbnw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         evt_valid,
	output logic         evt_ready,
	input  gbnw_status_t status,
	output gbnw_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic done;

	assign evt_ready      = (state_q == ST_IDLE);
	assign cmd.load_event = evt_ready && evt_valid;
	assign cmd.emit       = (state_q == ST_EMIT) && status.out_free;
	// burst ends on a status item or on the final send
	assign done           = cmd.emit && (!status.can_send || status.last_send);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_event) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/gbnw_dp.sv
// ----------------------------------------------------------------------------
// gbnw_dp
// Datapath: window and sequence counters, configuration and result register.
// ----------------------------------------------------------------------------
module gbnw_dp
	import gbnw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  gbnw_cmd_t            cmd,
	output gbnw_status_t         status,
	input  logic [MODE_W-1:0]    mode,
	input  logic [SEQ_BITS-1:0]  ack_seq,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 res_ready,
	output logic                 res_valid,
	output logic                 res_send_valid,
	output logic [SEQ_BITS-1:0]  res_packet_seq,
	output logic                 res_last,
	output logic [WIN_W-1:0]     res_window,
	output logic                 res_all_acked
);

	logic [CNT_W-1:0]   acked_q;
	logic [CNT_W-1:0]   sent_q;
	logic [WIN_W-1:0]   win_q;
	logic [TOTAL_W-1:0] total_q;
	logic [BURST_W-1:0] n_q;
	logic               res_valid_q;

	logic [CNT_W-1:0] upto;
	logic [CNT_W-1:0] upto_c;
	logic [CNT_W-1:0] sent_nx;
	logic [CNT_W-1:0] total_x;
	logic [CNT_W-1:0] win_x;
	logic [WSUM_W-1:0] grow_sum;
	logic             more_after;

	// ack point, clamped to what has gone out
	assign upto     = CNT_W'(ack_seq) + CNT_W'(1);
	assign upto_c   = (upto > sent_q) ? sent_q : upto;
	assign grow_sum = WSUM_W'(win_q) + WSUM_W'(upto_c - acked_q);

	assign total_x = CNT_W'(total_q);
	assign win_x   = CNT_W'(win_q);
	assign sent_nx = sent_q + CNT_W'(1);

	assign status.can_send = (sent_q < total_x) && ((sent_q - acked_q) < win_x);
	assign more_after      = (sent_nx < total_x) && ((sent_nx - acked_q) < win_x);
	assign status.last_send = (n_q == BURST_W'(BURST_MAX - 1)) || !more_after;
	assign status.out_free  = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q     <= '0;
			sent_q      <= '0;
			win_q       <= WIN_RESET;
			total_q     <= TOTAL_RESET;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TOTAL:    total_q <= cfg_data[TOTAL_W-1:0];
					CFG_INIT_WIN: win_q   <= clamp_win(WSUM_W'(cfg_data[WIN_W-1:0]));
					default:      ;
				endcase
			end
			if (cmd.load_event) begin
				n_q <= '0;
				case (mode)
					MODE_ACK: begin
						if (upto_c > acked_q) begin
							win_q   <= clamp_win(grow_sum);
							acked_q <= upto_c;
						end
					end
					MODE_TIMEOUT: begin
						// go back to the acked point
						sent_q <= acked_q;
						win_q  <= clamp_win(WSUM_W'(win_q >> 1));
					end
					default: ;
				endcase
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
				if (status.can_send) begin
					sent_q <= sent_nx;
					n_q    <= n_q + BURST_W'(1);
				end
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_send_valid <= status.can_send;
			res_packet_seq <= status.can_send ? sent_q[SEQ_BITS-1:0] : '0;
			res_last       <= !status.can_send || status.last_send;
			res_window     <= win_q;
			res_all_acked  <= (acked_q >= total_x);
		end
	end

	assign res_valid = res_valid_q;

endmodule

### sv/go_back_n_window_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_window_sender
// Sender side of a go-back-N sliding window with window growth and halving.
// ----------------------------------------------------------------------------
// usage:
//   evt channel takes one event (start kick, ack with cumulative sequence,
//   timeout). res channel returns the items the event causes: one send order
//   per packet the window allows, or one status item when nothing may go out.
//   the final item of an event has last set.
//   cfg port writes total_packets (index 0) and initial_window (index 1);
//   writing initial_window also loads the live window, clamped to 1..64.
// timing:
//   an event is accepted while the block is idle; its counters update on the
//   edge that accepts it. results then leave one per cycle, 1 to 64 of them,
//   while the receiver keeps taking them. the result register holds one item;
//   a stalled receiver pauses the burst in place. the next event is taken once
//   the last item is in the result register.
// reset:
//   counters clear, window loads 3, total_packets loads 1, no result pending.
// ----------------------------------------------------------------------------
module go_back_n_window_sender
	import gbnw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	gbnw_evt_if.sink             evt,
	gbnw_res_if.source           res,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	gbnw_cmd_t    cmd;
	gbnw_status_t status;

	gbnw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gbnw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.mode           (evt.mode),
		.ack_seq        (evt.ack_seq),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.res_ready      (res.ready),
		.res_valid      (res.valid),
		.res_send_valid (res.send_valid),
		.res_packet_seq (res.packet_seq),
		.res_last       (res.last),
		.res_window     (res.window),
		.res_all_acked  (res.all_acked)
	);

endmodule
